// File: src/itoa_pkg.sv
package itoa_pkg;

   // Default operand width and radix limits
   localparam int VALUE_BITS_DEF = 32;
   localparam int RADIX_BITS     = 6;
   localparam int CHAR_BITS      = 8;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN    = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX    = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_SIGNED = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET  = 6'd10;

   localparam logic [CHAR_BITS-1:0] MINUS_CHAR = 8'h2D;
   localparam logic [CHAR_BITS-1:0] ZERO_CHAR  = 8'h30;
   localparam logic [CHAR_BITS-1:0] ALPHA_BASE = 8'h37;   // 'A' minus ten
   localparam logic [CHAR_BITS-1:0] ERROR_CHAR = 8'h00;

   // Status of the shared divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Map a digit value 0..35 to '0'..'9', 'A'..'Z'
   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
      logic [CHAR_BITS-1:0] ext;
      ext = {{(CHAR_BITS-RADIX_BITS){1'b0}}, d};
      if (d < 6'd10) begin
         return ZERO_CHAR + ext;
      end
      return ALPHA_BASE + ext;
   endfunction

endpackage

// File: src/itoa_divider.sv
module itoa_divider
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [RADIX_BITS-1:0] divisor,
   output div_stat_type          stat,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [RADIX_BITS-1:0] remainder
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [RADIX_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RADIX_BITS:0]   trial;
   logic [RADIX_BITS:0]   diff;
   logic                  fits;

   // One restoring step: shift in next dividend bit, subtract if it fits
   assign trial = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(VALUE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

// File: src/itoa_digit_buf.sv
module itoa_digit_buf
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(VALUE_BITS)-1:0] wr_addr,
   input  logic [RADIX_BITS-1:0]         wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(VALUE_BITS)-1:0] rd_addr,
   output logic [RADIX_BITS-1:0]         rd_data
);

   logic [RADIX_BITS-1:0] mem [VALUE_BITS];
   logic [RADIX_BITS-1:0] rd_data_ff;

   // Store digits least significant first
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/integer_to_radix_ascii.sv
// For each value, every digit comes from one division through the shared bit-serial
// divider; then a minus sign is sent for a negative radix-10 value, and then each
// character is read from the digit store and sent. One value at a time: a new
// request is taken only after the last character has been loaded for output.
// Reset (synchronous, active high) clears the sequencer and output valid, and sets
// the radix register to 10.
module integer_to_radix_ascii
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // csr
   input  logic                                 csr_wr_en,
   input  logic [RADIX_BITS-1:0]                csr_wr_data,   // radix
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((VALUE_BITS+7)/8)*8-1:0]      req_tdata,     // [VALUE_BITS-1:0] value
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [CHAR_BITS-1:0]                 rsp_tdata,     // [7:0] text_char
   output logic                                 rsp_tlast,     // last_char
   output logic                                 rsp_tuser      // [0] bad_radix
);

   localparam int ADDR_BITS = $clog2(VALUE_BITS);
   localparam int NDIG_BITS = $clog2(VALUE_BITS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ERR  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;
   localparam logic [2:0] ST_LOAD = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] work_ff, work_in;
   logic [NDIG_BITS-1:0]  ndig_ff, ndig_in;
   logic [ADDR_BITS-1:0]  rd_addr_ff, rd_addr_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_BITS-1:0]  out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_bad_ff, out_bad_in;

   logic                  req_fire;
   logic                  out_free;
   logic                  radix_bad;
   logic [VALUE_BITS-1:0] in_value;
   logic                  in_neg;
   logic                  div_start;
   div_stat_type          div_stat;
   logic [VALUE_BITS-1:0] div_quot;
   logic [RADIX_BITS-1:0] div_rem;
   logic                  buf_wr_en;
   logic                  buf_rd_en;
   logic [RADIX_BITS-1:0] buf_rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign radix_bad  = (radix_ff < RADIX_MIN) || (radix_ff > RADIX_MAX);
   assign in_value   = req_tdata[VALUE_BITS-1:0];
   assign in_neg     = (radix_ff == RADIX_SIGNED) && in_value[VALUE_BITS-1];

   // Radix register
   always_comb begin
      radix_in = radix_ff;
      if (csr_wr_en) begin
         radix_in = csr_wr_data;
      end
   end

   // Shared bit-serial divider
   itoa_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (work_in),
      .divisor   (radix_ff),
      .stat      (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Digit store, read back most significant first
   itoa_digit_buf #(
      .VALUE_BITS (VALUE_BITS)
   ) u_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (ndig_ff[ADDR_BITS-1:0]),
      .wr_data (div_rem),
      .rd_en   (buf_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (buf_rd_data)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      work_in      = work_ff;
      ndig_in      = ndig_ff;
      rd_addr_in   = rd_addr_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;
      div_start    = 1'b0;
      buf_wr_en    = 1'b0;
      buf_rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in  = in_neg;
               work_in = in_neg ? VALUE_BITS'(~in_value + 1'b1) : in_value;
               ndig_in = '0;
               if (radix_bad) begin
                  state_in = ST_ERR;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ERROR_CHAR;
               out_last_in  = 1'b1;
               out_bad_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               buf_wr_en = 1'b1;
               ndig_in   = ndig_ff + 1'b1;
               work_in   = div_quot;
               if (div_quot == '0) begin
                  rd_addr_in = ndig_ff[ADDR_BITS-1:0];
                  state_in   = ST_SIGN;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_SIGN: begin
            if (!neg_ff) begin
               state_in = ST_READ;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = MINUS_CHAR;
               out_last_in  = 1'b0;
               out_bad_in   = 1'b0;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            buf_rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = digit_char(buf_rd_data);
               out_last_in  = (rd_addr_ff == '0);
               out_bad_in   = 1'b0;
               if (rd_addr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_addr_in = rd_addr_ff - 1'b1;
                  state_in   = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         out_valid_ff <= out_valid_in;
      end
      neg_ff      <= neg_in;
      work_ff     <= work_in;
      ndig_ff     <= ndig_in;
      rd_addr_ff  <= rd_addr_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_bad_ff;

`ifndef ASSERT_OFF
   // No new value is taken while the divider still works
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_stat.busy)
      else $error("request accepted while divider busy");

   // Error transaction is a single zero character marked last
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == ERROR_CHAR))
      else $error("malformed bad radix transaction");

   // The sign never ends a text
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser && rsp_tdata == MINUS_CHAR) |-> !rsp_tlast)
      else $error("minus sign marked last");

   // Digit count never exceeds the operand width
   a_ndig_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (ndig_ff < NDIG_BITS'(VALUE_BITS)))
      else $error("digit count overflow");
`endif

endmodule
